/* rtl/dtsf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtsf_pkg
// Shared types, register map, reset values and sensor B conversions for the
// dual temperature sensor fusion block.
// ----------------------------------------------------------------------------
package dtsf_pkg;

	typedef enum logic [1:0] {
		MODE_A_READ = 2'd0,
		MODE_B_READ = 2'd1,
		MODE_FUSE   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	localparam logic [2:0] REG_STALE_LIMIT  = 3'd0;
	localparam logic [2:0] REG_FAIL_LIMIT   = 3'd1;
	localparam logic [2:0] REG_B_TEMP_LOW   = 3'd2;
	localparam logic [2:0] REG_B_TEMP_HIGH  = 3'd3;
	localparam logic [2:0] REG_DOUBLE_CHECK = 3'd4;
	localparam logic [2:0] REG_AGREE_WINDOW = 3'd5;

	localparam logic [15:0]        RST_STALE_LIMIT  = 16'd2000;
	localparam logic [2:0]         RST_FAIL_LIMIT   = 3'd3;
	localparam logic signed [14:0] RST_B_TEMP_LOW   = -15'sd4000;
	localparam logic signed [14:0] RST_B_TEMP_HIGH  = 15'sd12500;
	localparam logic               RST_DOUBLE_CHECK = 1'b0;
	localparam logic [13:0]        RST_AGREE_WINDOW = 14'd200;

	localparam logic [2:0]         FAIL_SAT   = 3'd7;
	localparam logic signed [15:0] A_TEMP_MIN = -16'sd5000;
	localparam logic signed [15:0] A_TEMP_MAX = 16'sd15000;
	localparam logic signed [15:0] HUM_MAX    = 16'sd10000;

	typedef struct packed {
		logic [15:0]        b_hum_raw;
		logic [15:0]        b_temp_raw;
		logic signed [15:0] a_temp;
		logic               retry_ok;
		logic               read_ok;
		logic               ack_ok;
		logic [31:0]        now_ms;
	} item_t;

	typedef struct packed {
		logic               a_fault;
		logic               recovery_request;
		logic               humidity_present;
		logic               fused_valid;
		logic [13:0]        fused_humidity;
		logic signed [14:0] fused_temp;
	} result_t;

	// floor(x / 65535) for x below 2^31, via the 2^16 - 1 identity
	function automatic logic [15:0] div_65535(input logic [31:0] x);
		logic [31:0] s;
		s = x + {16'd0, x[31:16]} + 32'd1;
		return s[31:16];
	endfunction

	function automatic logic signed [14:0] b_temp_conv(input logic [15:0] raw);
		logic [15:0]        q;
		logic signed [15:0] t;
		q = div_65535({16'd0, raw} * 32'd17500 + 32'd32767);
		t = $signed({1'b0, q[14:0]}) - 16'sd4500;
		return t[14:0];
	endfunction

	function automatic logic [13:0] b_hum_conv(input logic [15:0] raw);
		logic [15:0]        q;
		logic signed [15:0] h;
		logic [13:0]        r;
		q = div_65535({16'd0, raw} * 32'd12500 + 32'd32767);
		h = $signed({1'b0, q[14:0]}) - 16'sd600;
		priority if (h > HUM_MAX) begin
			r = HUM_MAX[13:0];
		end else if (h < 16'sd0) begin
			r = 14'd0;
		end else begin
			r = h[13:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/dual_temp_sensor_fusion_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dual_temp_sensor_fusion_top
// Sensor A read supervision, sensor B conversion, validity caches and fusion
// of the two temperature readings, one result word per input word.
// ----------------------------------------------------------------------------
// channel   | direction | contents
// s_axis    | in        | tuser mode, tdata time, read outcomes, raw readings
// m_axis    | out       | tdata fused reading and status flags
// apb       | in/out    | six configuration registers at 4*index
//
// per word: input register, then all state and the result register update
// together when the word moves on; a word can be taken every cycle while m_axis is not stalled
// m_axis valid once the word has moved from the input register into the result register
// arst_n clears caches, counters, stored reading and registers to defaults
// a stalled m_axis holds the result while one more word waits in the input register
module dual_temp_sensor_fusion_top
	import dtsf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// now_ms[31:0] ack_ok[32] read_ok[33] retry_ok[34] a_temp[50:35]
	// b_temp_raw[66:51] b_hum_raw[82:67] zero[87:83]
	input  wire logic [87:0] s_axis_tdata,
	// mode[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// fused_temp[14:0] fused_humidity[28:15] fused_valid[29]
	// humidity_present[30] recovery_request[31] a_fault[32] zero[39:33]
	output logic [39:0]      m_axis_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [15:0]        stale_q;
	logic [2:0]         fail_limit_q;
	logic signed [14:0] b_low_q;
	logic signed [14:0] b_high_q;
	logic               dbl_q;
	logic [13:0]        agree_q;

	logic               s1_v_q;
	item_t              item_s1;
	logic [1:0]         s_axis_tuser_s1_q;
	mode_t              mode_s1;
	logic               fire;

	logic signed [14:0] a_temp_q, a_temp_d;
	logic               a_valid_q, a_valid_d;
	logic [31:0]        a_time_q, a_time_d;
	logic [2:0]         a_fail_q, a_fail_d;
	logic               a_fault_q, a_fault_d;
	logic signed [14:0] b_temp_q, b_temp_d;
	logic [13:0]        b_hum_q, b_hum_d;
	logic               b_valid_q, b_valid_d;
	logic [31:0]        b_time_q, b_time_d;
	logic signed [14:0] st_temp_q, st_temp_d;
	logic [13:0]        st_hum_q, st_hum_d;
	logic               st_valid_q, st_valid_d;
	logic               st_pres_q, st_pres_d;
	logic               recov_c;

	logic [2:0]         fail_inc;
	logic               at_limit;
	logic               a_ok_read;
	logic signed [14:0] bt_conv;
	logic [13:0]        bh_conv;
	logic               a_fresh;
	logic               b_fresh;
	logic signed [15:0] diff;
	logic [15:0]        adiff;
	logic signed [15:0] sum;

	result_t            res_c;
	logic               out_v_q;
	result_t            out_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q      <= RST_STALE_LIMIT;
			fail_limit_q <= RST_FAIL_LIMIT;
			b_low_q      <= RST_B_TEMP_LOW;
			b_high_q     <= RST_B_TEMP_HIGH;
			dbl_q        <= RST_DOUBLE_CHECK;
			agree_q      <= RST_AGREE_WINDOW;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_STALE_LIMIT:  stale_q      <= pwdata[15:0];
				REG_FAIL_LIMIT:   fail_limit_q <= pwdata[2:0];
				REG_B_TEMP_LOW:   b_low_q      <= pwdata[14:0];
				REG_B_TEMP_HIGH:  b_high_q     <= pwdata[14:0];
				REG_DOUBLE_CHECK: dbl_q        <= pwdata[0];
				REG_AGREE_WINDOW: agree_q      <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_STALE_LIMIT:  prdata = {16'd0, stale_q};
			REG_FAIL_LIMIT:   prdata = {29'd0, fail_limit_q};
			REG_B_TEMP_LOW:   prdata = 32'(b_low_q);
			REG_B_TEMP_HIGH:  prdata = 32'(b_high_q);
			REG_DOUBLE_CHECK: prdata = {31'd0, dbl_q};
			REG_AGREE_WINDOW: prdata = {18'd0, agree_q};
			default:          prdata = 32'd0;
		endcase
	end

	// handshake: input register moves on when the result register is free
	assign fire          = s1_v_q && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !s1_v_q || fire;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'd0, out_q};
	assign mode_s1       = mode_t'(s_axis_tuser_s1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_v_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1           <= item_t'(s_axis_tdata[82:0]);
			s_axis_tuser_s1_q <= s_axis_tuser;
		end
	end

	assign fail_inc  = (a_fail_q == FAIL_SAT) ? FAIL_SAT : a_fail_q + 3'd1;
	assign at_limit  = fail_inc >= fail_limit_q;
	assign bt_conv   = b_temp_conv(item_s1.b_temp_raw);
	assign bh_conv   = b_hum_conv(item_s1.b_hum_raw);
	assign a_fresh   = a_valid_q && !a_fault_q
	                   && ((item_s1.now_ms - a_time_q) < {16'd0, stale_q});
	assign b_fresh   = b_valid_q && ((item_s1.now_ms - b_time_q) < {16'd0, stale_q});
	assign diff      = 16'(a_temp_q) - 16'(b_temp_q);
	assign adiff     = diff[15] ? 16'(-diff) : 16'(diff);
	assign sum       = 16'(a_temp_q) + 16'(b_temp_q);

	always_comb begin
		a_temp_d   = a_temp_q;
		a_valid_d  = a_valid_q;
		a_time_d   = a_time_q;
		a_fail_d   = a_fail_q;
		a_fault_d  = a_fault_q;
		b_temp_d   = b_temp_q;
		b_hum_d    = b_hum_q;
		b_valid_d  = b_valid_q;
		b_time_d   = b_time_q;
		st_temp_d  = st_temp_q;
		st_hum_d   = st_hum_q;
		st_valid_d = st_valid_q;
		st_pres_d  = st_pres_q;
		recov_c    = 1'b0;
		a_ok_read  = 1'b0;
		unique case (mode_s1)
			MODE_A_READ: begin
				if (!a_fault_q) begin
					priority if (!item_s1.ack_ok) begin
						a_fail_d = fail_inc;
						if (at_limit) begin
							a_fault_d = 1'b1;
						end
					end else if (!item_s1.read_ok) begin
						a_fail_d = fail_inc;
						if (at_limit) begin
							recov_c = 1'b1;
							if (item_s1.retry_ok) begin
								a_fail_d  = 3'd0;
								a_ok_read = 1'b1;
							end else begin
								a_fault_d = 1'b1;
							end
						end
					end else begin
						a_fail_d  = 3'd0;
						a_ok_read = 1'b1;
					end
					if (a_ok_read && item_s1.a_temp > A_TEMP_MIN
					    && item_s1.a_temp < A_TEMP_MAX) begin
						a_temp_d  = item_s1.a_temp[14:0];
						a_valid_d = 1'b1;
						a_time_d  = item_s1.now_ms;
					end else begin
						a_valid_d = 1'b0;
					end
				end
			end
			MODE_B_READ: begin
				if (item_s1.ack_ok && item_s1.read_ok && bt_conv >= b_low_q
				    && bt_conv <= b_high_q) begin
					b_temp_d  = bt_conv;
					b_hum_d   = bh_conv;
					b_valid_d = 1'b1;
					b_time_d  = item_s1.now_ms;
				end else begin
					b_valid_d = 1'b0;
				end
			end
			MODE_FUSE: begin
				priority if (b_fresh) begin
					if (a_fresh && adiff < {2'd0, agree_q} && dbl_q) begin
						st_temp_d = sum[15:1];
					end else begin
						st_temp_d = b_temp_q;
					end
					st_hum_d   = b_hum_q;
					st_valid_d = 1'b1;
					st_pres_d  = 1'b1;
				end else if (a_fresh) begin
					st_temp_d  = a_temp_q;
					st_hum_d   = 14'd0;
					st_valid_d = 1'b1;
					st_pres_d  = 1'b0;
				end else begin
				end
			end
			MODE_NONE: ;
		endcase

		// b cache stands in when nothing has been stored yet
		if (!st_valid_d && b_valid_d) begin
			res_c.fused_temp       = b_temp_d;
			res_c.fused_humidity   = b_hum_d;
			res_c.fused_valid      = 1'b1;
			res_c.humidity_present = 1'b1;
		end else begin
			res_c.fused_temp       = st_temp_d;
			res_c.fused_humidity   = st_hum_d;
			res_c.fused_valid      = st_valid_d;
			res_c.humidity_present = st_pres_d;
		end
		res_c.recovery_request = recov_c;
		res_c.a_fault          = a_fault_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_temp_q   <= '0;
			a_valid_q  <= 1'b0;
			a_time_q   <= '0;
			a_fail_q   <= '0;
			a_fault_q  <= 1'b0;
			b_temp_q   <= '0;
			b_hum_q    <= '0;
			b_valid_q  <= 1'b0;
			b_time_q   <= '0;
			st_temp_q  <= '0;
			st_hum_q   <= '0;
			st_valid_q <= 1'b0;
			st_pres_q  <= 1'b0;
		end else if (fire) begin
			a_temp_q   <= a_temp_d;
			a_valid_q  <= a_valid_d;
			a_time_q   <= a_time_d;
			a_fail_q   <= a_fail_d;
			a_fault_q  <= a_fault_d;
			b_temp_q   <= b_temp_d;
			b_hum_q    <= b_hum_d;
			b_valid_q  <= b_valid_d;
			b_time_q   <= b_time_d;
			st_temp_q  <= st_temp_d;
			st_hum_q   <= st_hum_d;
			st_valid_q <= st_valid_d;
			st_pres_q  <= st_pres_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fire) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res_c;
		end
	end

`ifndef SYNTHESIS
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		a_fault_q |=> a_fault_q)
		else $error("sensor A fault flag cleared");

	stored_pres_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!st_valid_q |-> !st_pres_q)
		else $error("stored humidity present without valid reading");

	recovery_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		fire && recov_c |=> (a_fail_q == 3'd0) || a_fault_q)
		else $error("recovery left failure count pending");

	a_cache_range: assert property (@(posedge clk) disable iff (!arst_n)
		a_valid_q |-> (16'(a_temp_q) > A_TEMP_MIN) && (16'(a_temp_q) < A_TEMP_MAX))
		else $error("sensor A cache holds out of range temperature");
`endif

endmodule
`default_nettype wire
